// ----- hdl/vbws_pkg.sv -----
// Shared types, widths, constants and the arctangent table for the bearing tracker.
// No dependencies; every other file imports this package.
package vbws_pkg;

    localparam int POS_W      = 24;
    localparam int D_W        = 25;
    localparam int P_W        = 50;
    localparam int V_W        = 54;
    localparam int Z_W        = 28;
    localparam int SQ_W       = 51;
    localparam int SQ_STEPS   = 25;
    localparam int NORM_STEPS = 6;
    localparam int NORM_TOP   = 49;
    localparam int ANGLE_STEPS_DEF = 16;

    localparam int DIST_W = 25;
    localparam int BEAR_W = 16;
    localparam int SPD_W  = 14;
    localparam int VHA_W  = 15;
    localparam int WS_W   = 13;
    localparam int SR_W   = 9;
    localparam int PRD_W  = WS_W + SR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int IN_W   = 6 * POS_W;
    localparam int OUT_W  = 72;

    localparam logic signed [Z_W-1:0] BEAR_MAX    = Z_W'(25736);
    localparam logic signed [Z_W-1:0] HALF_PI_Q24 = Z_W'(26353589);
    localparam logic signed [Z_W-1:0] ROUND_Q     = Z_W'(1024);
    localparam int Z_DROP = 11;
    localparam logic [SPD_W-1:0] SPD_SAT = SPD_W'(8191);
    localparam logic [PRD_W-1:0] RATIO_HALF = PRD_W'(128);
    localparam int RATIO_FRAC = 8;

    localparam logic [VHA_W-1:0] VHA_RST = VHA_W'(3217);
    localparam logic [WS_W-1:0]  WS_RST  = WS_W'(1024);
    localparam logic [SR_W-1:0]  SR_RST  = SR_W'(128);

    localparam logic [CFG_IDX_W-1:0] REG_VIEW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RATIO = CFG_IDX_W'(2);

    typedef struct packed {
        logic signed [V_W-1:0] x;
        logic signed [V_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  zero;
    } t_vec;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] r;
    } t_sq;

    localparam logic [Z_W-1:0] ATAN_TAB [8] = '{
        Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
        Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069)
    };

    // atan(2^-i) in 2^-24 rad; past the table it is 2^(24-i), and zero for i above 24
    function automatic logic signed [Z_W-1:0] atan_q24(input int i);
        logic signed [Z_W-1:0] res;
        if (i < 8) begin
            res = ATAN_TAB[i];
        end else if (i <= 24) begin
            res = Z_W'(1) << (24 - i);
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// ----- hdl/vbws_norm_cell.sv -----
// Normalizing cell: scales the vector left by a fixed power of two while it stays small.
// Depends on vbws_pkg.
module vbws_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  vbws_pkg::t_vec i_vec,
    output vbws_pkg::t_vec o_vec
);
    import vbws_pkg::*;

    logic signed [V_W-1:0] ax, ay;
    logic signed [V_W-1:0] lim;
    t_vec n_vec, r_vec;

    always_comb begin
        ax    = i_vec.x[V_W-1] ? -i_vec.x : i_vec.x;
        ay    = i_vec.y[V_W-1] ? -i_vec.y : i_vec.y;
        lim   = V_W'(1) <<< (NORM_TOP - SHIFT);
        n_vec = i_vec;
        if (ax < lim && ay < lim) begin
            n_vec.x = i_vec.x <<< SHIFT;
            n_vec.y = i_vec.y <<< SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_vec <= n_vec;
    end

    assign o_vec = r_vec;
endmodule

// ----- hdl/vbws_cordic_cell.sv -----
// One vectoring rotation step with a fixed shift and arctangent constant.
// Depends on vbws_pkg.
module vbws_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  vbws_pkg::t_vec i_vec,
    output vbws_pkg::t_vec o_vec
);
    import vbws_pkg::*;

    localparam logic signed [Z_W-1:0] ANG = atan_q24(SHIFT);

    logic signed [V_W-1:0] xs, ys;
    t_vec n_vec, r_vec;

    always_comb begin
        xs    = i_vec.x >>> SHIFT;
        ys    = i_vec.y >>> SHIFT;
        n_vec = i_vec;
        if (!i_vec.y[V_W-1]) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + ANG;
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_vec <= n_vec;
    end

    assign o_vec = r_vec;
endmodule

// ----- hdl/vbws_sqrt_cell.sv -----
// One digit step of the restoring integer square root.
// Depends on vbws_pkg.
module vbws_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  vbws_pkg::t_sq i_sq,
    output vbws_pkg::t_sq o_sq
);
    import vbws_pkg::*;

    localparam int BIT_EXP = 2 * (SQ_STEPS - 1 - STEP);

    logic [SQ_W-1:0] bitv, t;
    t_sq n_sq, r_sq;

    always_comb begin
        bitv = SQ_W'(1) << BIT_EXP;
        t    = i_sq.r + bitv;
        if (i_sq.n >= t) begin
            n_sq.n = i_sq.n - t;
            n_sq.r = (i_sq.r >> 1) + bitv;
        end else begin
            n_sq.n = i_sq.n;
            n_sq.r = i_sq.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_sq <= n_sq;
    end

    assign o_sq = r_sq;
endmodule

// ----- hdl/vision_bearing_wheel_steer.sv -----
// Bearing tracker top level: frame rotation, CORDIC bearing, square-root distance, wheel commands.
// Depends on vbws_pkg, vbws_norm_cell, vbws_cordic_cell, vbws_sqrt_cell.

// Takes one item per clock unless m_axis_tready holds the output back, and returns one
// result per item, in order. An item passes three front stages (offsets, products,
// dot/cross sums), then two cell chains side by side, six normalizing cells, one
// quadrant cell and ANGLE_STEPS (16 by default) rotation cells for the bearing, and
// 25 root-digit cells for the distance; the shorter chain is padded to
// the longer one. Every stage hands on as soon as the next one is free, so bubbles
// close up and input is taken while a finished result waits at the output. Config
// registers are written through the cfg channel, which is always ready; write them
// only while no item is in flight.
module vision_bearing_wheel_steer #(
    parameter int ANGLE_STEPS = vbws_pkg::ANGLE_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // target_x, target_y, body_x, body_y, cam_x, cam_y (24 bit each, lowest first)
    input  logic [vbws_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // distance[24:0], bearing[40:25], right_speed[54:41], left_speed[68:55], zero fill
    output logic [vbws_pkg::OUT_W-1:0]     m_axis_tdata,
    // in_view
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vbws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vbws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vbws_pkg::*;

    localparam int LA = NORM_STEPS + 1 + ANGLE_STEPS;   // bearing chain length
    localparam int P  = (LA > SQ_STEPS) ? LA : SQ_STEPS;
    localparam int DA = P - LA;
    localparam int DS = P - SQ_STEPS;

    // config registers
    logic [VHA_W-1:0] r_vha;
    logic [WS_W-1:0]  r_ws;
    logic [SR_W-1:0]  r_sr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vha <= VHA_RST;
            r_ws  <= WS_RST;
            r_sr  <= SR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_VIEW:  r_vha <= i_cfg_data[VHA_W-1:0];
                REG_SPEED: r_ws  <= i_cfg_data[WS_W-1:0];
                REG_RATIO: r_sr  <= i_cfg_data[SR_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control: a stage loads when it is empty or its item moves on
    logic         r_v0, r_v1, r_v2, r_ov;
    logic [P-1:0] r_cv;
    logic         en0, en1, en2, en_o;
    logic [P-1:0] en_c;

    assign en_o = !r_ov || m_axis_tready;
    assign en_c[P-1] = !r_cv[P-1] || en_o;
    for (genvar j = 0; j < P - 1; j++) begin : g_en
        assign en_c[j] = !r_cv[j] || en_c[j+1];
    end
    assign en2 = !r_v2 || en_c[0];
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;
    assign s_axis_tready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_cv <= '0;
            r_ov <= 1'b0;
        end else begin
            if (en0) r_v0 <= s_axis_tvalid;
            if (en1) r_v1 <= r_v0;
            if (en2) r_v2 <= r_v1;
            if (en_c[0]) r_cv[0] <= r_v2;
            for (int j = 1; j < P; j++) begin
                if (en_c[j]) r_cv[j] <= r_cv[j-1];
            end
            if (en_o) r_ov <= r_cv[P-1];
        end
    end

    // stage 0: offsets from the base
    logic signed [D_W-1:0] n_dx, n_dy, n_hx, n_hy;
    logic signed [D_W-1:0] r_dx, r_dy, r_hx, r_hy;

    always_comb begin
        n_dx = D_W'($signed(s_axis_tdata[0*POS_W +: POS_W]))
             - D_W'($signed(s_axis_tdata[2*POS_W +: POS_W]));
        n_dy = D_W'($signed(s_axis_tdata[1*POS_W +: POS_W]))
             - D_W'($signed(s_axis_tdata[3*POS_W +: POS_W]));
        n_hx = D_W'($signed(s_axis_tdata[4*POS_W +: POS_W]))
             - D_W'($signed(s_axis_tdata[2*POS_W +: POS_W]));
        n_hy = D_W'($signed(s_axis_tdata[5*POS_W +: POS_W]))
             - D_W'($signed(s_axis_tdata[3*POS_W +: POS_W]));
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_hx <= n_hx;
            r_hy <= n_hy;
        end
    end

    // stage 1: products
    logic signed [P_W-1:0] r_pxhx, r_pyhy, r_pxhy, r_pyhx, r_pxx, r_pyy;
    logic signed [D_W-1:0] r1_dx, r1_dy;
    logic                  r1_hz;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pxhx <= P_W'(r_dx) * P_W'(r_hx);
            r_pyhy <= P_W'(r_dy) * P_W'(r_hy);
            r_pxhy <= P_W'(r_dx) * P_W'(r_hy);
            r_pyhx <= P_W'(r_dy) * P_W'(r_hx);
            r_pxx  <= P_W'(r_dx) * P_W'(r_dx);
            r_pyy  <= P_W'(r_dy) * P_W'(r_dy);
            r1_dx  <= r_dx;
            r1_dy  <= r_dy;
            r1_hz  <= (r_hx == '0) && (r_hy == '0);
        end
    end

    // stage 2: dot, cross and squared distance; camera on base falls back to the offset
    t_vec n_vec2, r_vec2;
    t_sq  n_sq2, r_sq2;

    always_comb begin
        if (r1_hz) begin
            n_vec2.x = V_W'(r1_dy);
            n_vec2.y = V_W'(r1_dx);
        end else begin
            n_vec2.x = V_W'(r_pxhx) + V_W'(r_pyhy);
            n_vec2.y = V_W'(r_pxhy) - V_W'(r_pyhx);
        end
        n_vec2.z    = '0;
        n_vec2.zero = (n_vec2.x == '0) && (n_vec2.y == '0);
        n_sq2.n     = SQ_W'($unsigned(r_pxx)) + SQ_W'($unsigned(r_pyy));
        n_sq2.r     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_vec2 <= n_vec2;
            r_sq2  <= n_sq2;
        end
    end

    // bearing chain
    t_vec w_a [LA+1];
    t_vec r_quad, n_quad;
    assign w_a[0] = r_vec2;

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        vbws_norm_cell #(.SHIFT(1 << (NORM_STEPS - 1 - j))) u_norm (
            .i_clk (i_clk),
            .i_en  (en_c[j]),
            .i_vec (w_a[j]),
            .o_vec (w_a[j+1])
        );
    end

    // quadrant fold into the right half plane
    always_comb begin
        n_quad = w_a[NORM_STEPS];
        if (w_a[NORM_STEPS].x[V_W-1]) begin
            if (!w_a[NORM_STEPS].y[V_W-1]) begin
                n_quad.x = w_a[NORM_STEPS].y;
                n_quad.y = -w_a[NORM_STEPS].x;
                n_quad.z = HALF_PI_Q24;
            end else begin
                n_quad.x = -w_a[NORM_STEPS].y;
                n_quad.y = w_a[NORM_STEPS].x;
                n_quad.z = -HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c[NORM_STEPS]) r_quad <= n_quad;
    end
    assign w_a[NORM_STEPS+1] = r_quad;

    for (genvar j = 0; j < ANGLE_STEPS; j++) begin : g_cordic
        vbws_cordic_cell #(.SHIFT(j)) u_cordic (
            .i_clk (i_clk),
            .i_en  (en_c[NORM_STEPS+1+j]),
            .i_vec (w_a[NORM_STEPS+1+j]),
            .o_vec (w_a[NORM_STEPS+2+j])
        );
    end

    t_vec a_end;
    if (DA > 0) begin : g_adly
        t_vec r_ad [DA];
        for (genvar k = 0; k < DA; k++) begin : g_tap
            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (en_c[LA]) r_ad[0] <= w_a[LA];
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (en_c[LA+k]) r_ad[k] <= r_ad[k-1];
                end
            end
        end
        assign a_end = r_ad[DA-1];
    end else begin : g_anodly
        assign a_end = w_a[LA];
    end

    // distance chain
    t_sq w_q [SQ_STEPS+1];
    assign w_q[0] = r_sq2;

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        vbws_sqrt_cell #(.STEP(j)) u_sqrt (
            .i_clk (i_clk),
            .i_en  (en_c[j]),
            .i_sq  (w_q[j]),
            .o_sq  (w_q[j+1])
        );
    end

    t_sq q_end;
    if (DS > 0) begin : g_sdly
        t_sq r_sd [DS];
        for (genvar k = 0; k < DS; k++) begin : g_tap
            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (en_c[SQ_STEPS]) r_sd[0] <= w_q[SQ_STEPS];
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (en_c[SQ_STEPS+k]) r_sd[k] <= r_sd[k-1];
                end
            end
        end
        assign q_end = r_sd[DS-1];
    end else begin : g_snodly
        assign q_end = w_q[SQ_STEPS];
    end

    // output stage: round, clamp, view test, wheel commands
    logic signed [Z_W-1:0]    zr, zc;
    logic signed [BEAR_W-1:0] n_bear;
    logic [BEAR_W-1:0]        abs_bear;
    logic                     n_view;
    logic [PRD_W-1:0]         slow_p;
    logic [SPD_W-1:0]         slow;
    logic signed [SPD_W-1:0]  spd, inner, n_right, n_left;
    logic [DIST_W-1:0]        n_dist;

    always_comb begin
        zr = (a_end.z + ROUND_Q) >>> Z_DROP;
        if (a_end.zero)          zc = '0;
        else if (zr > BEAR_MAX)  zc = BEAR_MAX;
        else if (zr < -BEAR_MAX) zc = -BEAR_MAX;
        else                     zc = zr;
        n_bear   = zc[BEAR_W-1:0];
        abs_bear = n_bear[BEAR_W-1] ? BEAR_W'(-n_bear) : BEAR_W'(n_bear);
        n_view   = abs_bear <= BEAR_W'(r_vha);

        slow_p = (PRD_W'(r_sr) * PRD_W'(r_ws) + RATIO_HALF) >> RATIO_FRAC;
        slow   = (slow_p > PRD_W'(SPD_SAT)) ? SPD_SAT : slow_p[SPD_W-1:0];
        spd    = $signed(SPD_W'(r_ws));
        inner  = $signed(slow);

        if (!n_view) begin
            n_right = spd;
            n_left  = -spd;
        end else if (n_bear > 0) begin
            n_right = spd;
            n_left  = inner;
        end else begin
            n_right = inner;
            n_left  = spd;
        end

        n_dist = q_end.r[DIST_W-1:0] + DIST_W'(q_end.n > q_end.r);
    end

    logic [DIST_W-1:0]        r_dist;
    logic signed [BEAR_W-1:0] r_bear;
    logic                     r_view;
    logic signed [SPD_W-1:0]  r_right, r_left;

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_dist  <= n_dist;
            r_bear  <= n_bear;
            r_view  <= n_view;
            r_right <= n_right;
            r_left  <= n_left;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b000, r_left, r_right, r_bear, r_dist};
    assign m_axis_tuser  = r_view;

`ifndef NO_ASSERTIONS
    a_bear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_bear <= BEAR_W'(25736)) && (r_bear >= -BEAR_W'(25736)))
        else $error("bearing out of range");

    a_view_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_view |-> (r_bear <= $signed({1'b0, r_vha}))
                        && (r_bear >= -$signed({1'b0, r_vha})))
        else $error("in_view set with bearing outside view");

    a_turn_in_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_view |-> (r_left == -r_right))
        else $error("out of view without turn in place");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv[P-1] && !en_o |=> r_cv[P-1])
        else $error("item lost at chain end");
`endif

endmodule
